>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> rtl/core/crt_pkg.sv
// ----------------------------------------------------------------------------
// Code range table package
// Operation and status codes and the request token that walks the cell chain.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int ADDR_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL = 2'd1;
  localparam logic [OP_W-1:0] OP_LKC = 2'd2;
  localparam logic [OP_W-1:0] OP_LKP = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERLAP   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic              active;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] first_addr;
    logic [ADDR_W-1:0] last_addr;
    logic              legal;
    logic              overlap;
    logic              free_found;
    logic              done;
    logic              hit_legal;
    logic [ADDR_W-1:0] hit_first;
    logic [ADDR_W-1:0] hit_last;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] first_addr;
    logic [ADDR_W-1:0] last_addr;
    logic              legal;
  } wr_t;

endpackage

>>> rtl/core/crt_cell.sv
// ----------------------------------------------------------------------------
// Code range table cell
// Holds one range slot and checks the passing request against it.
// ----------------------------------------------------------------------------
module crt_cell #(
  parameter int IDX        = 0,
  parameter int IDX_W      = 4,
  parameter int PAGE_SHIFT = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  crt_pkg::tok_t      tok_in,
  input  logic [IDX_W-1:0]   free_in,
  input  crt_pkg::wr_t       wr,
  input  logic [IDX_W-1:0]   wr_idx,
  output crt_pkg::tok_t      tok_out,
  output logic [IDX_W-1:0]   free_out
);

  logic                       vld_r;
  logic                       vld_nxt;
  logic [crt_pkg::ADDR_W-1:0] first_r;
  logic [crt_pkg::ADDR_W-1:0] last_r;
  logic                       legal_r;
  crt_pkg::tok_t              tok_r;
  crt_pkg::tok_t              tok_nxt;
  logic [IDX_W-1:0]           free_r;
  logic [IDX_W-1:0]           free_nxt;
  logic                       wr_hit;
  logic                       inside_hit;
  logic                       page_hit;

  assign wr_hit     = wr.en && (wr_idx == IDX_W'(IDX));
  assign inside_hit = (tok_in.first_addr >= first_r) && (tok_in.first_addr <= last_r);
  assign page_hit   = ((tok_in.first_addr >> PAGE_SHIFT) == (first_r >> PAGE_SHIFT)) ||
                      ((tok_in.first_addr >> PAGE_SHIFT) == (last_r >> PAGE_SHIFT));

  always_comb begin
    tok_nxt  = tok_in;
    free_nxt = free_in;
    vld_nxt  = vld_r;
    if (tok_in.active && vld_r) begin
      case (tok_in.op)
        crt_pkg::OP_ADD: begin
          if ((tok_in.first_addr <= last_r) && (tok_in.last_addr >= first_r)) begin
            tok_nxt.overlap = 1'b1;
          end
        end
        crt_pkg::OP_DEL: begin
          if (!tok_in.done &&
              ((first_r == tok_in.first_addr) || (last_r == tok_in.last_addr))) begin
            tok_nxt.done = 1'b1;
            vld_nxt      = 1'b0;
          end
        end
        crt_pkg::OP_LKC, crt_pkg::OP_LKP: begin
          if (!tok_in.done &&
              (inside_hit || ((tok_in.op == crt_pkg::OP_LKP) && page_hit))) begin
            tok_nxt.done      = 1'b1;
            tok_nxt.hit_legal = legal_r;
            tok_nxt.hit_first = first_r;
            tok_nxt.hit_last  = last_r;
          end
        end
        default: begin
          tok_nxt = tok_in;
        end
      endcase
    end
    if (tok_in.active && !vld_r && (tok_in.op == crt_pkg::OP_ADD) &&
        !tok_in.free_found) begin
      tok_nxt.free_found = 1'b1;
      free_nxt           = IDX_W'(IDX);
    end
    if (wr_hit) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_r <= free_nxt;
    if (wr_hit) begin
      first_r <= wr.first_addr;
      last_r  <= wr.last_addr;
      legal_r <= wr.legal;
    end
  end

  assign tok_out  = tok_r;
  assign free_out = free_r;

endmodule

>>> rtl/core/code_range_table.sv
// ----------------------------------------------------------------------------
// Code range table
// Range table with add, delete, containing lookup and same-page lookup.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                        | Direction
//  request  | in_valid, in_stall, in_operation, in_*_addr  | into block
//  result   | out_valid, out_stall, out_status, out_found* | out of block
//
// A request walks the row of ENTRIES cells, one cell per cycle, behind an entry
// register; its result then passes a holding stage and an output register. A new
// request is taken only once the last one has left the last cell and its result
// can move on. An add is written into its slot as the request leaves the last
// cell. Reset empties the table at once. A result waiting on out_stall sits in
// the holding stage, and no further request is taken meanwhile.
module code_range_table #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [crt_pkg::OP_W-1:0]     in_operation,
  input  logic [crt_pkg::ADDR_W-1:0]   in_first_addr,
  input  logic [crt_pkg::ADDR_W-1:0]   in_last_addr,
  input  logic                         in_legal_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [crt_pkg::STAT_W-1:0]   out_status,
  output logic                         out_found,
  output logic                         out_found_legal,
  output logic [crt_pkg::ADDR_W-1:0]   out_found_first,
  output logic [crt_pkg::ADDR_W-1:0]   out_found_last
);

  `include "assert_macros.svh"

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  crt_pkg::tok_t              tok [ENTRIES+1];
  logic [IDX_W-1:0]           free_idx [ENTRIES+1];
  logic [ENTRIES:0]           act_vec;
  crt_pkg::tok_t              tok0_r;
  logic [IDX_W-1:0]           free0_r;
  crt_pkg::tok_t              tail;
  crt_pkg::wr_t               wr;
  logic                       busy_r;
  logic                       res_vld_r;
  logic [crt_pkg::STAT_W-1:0] res_status_r;
  logic                       res_found_r;
  logic                       res_legal_r;
  logic [crt_pkg::ADDR_W-1:0] res_first_r;
  logic [crt_pkg::ADDR_W-1:0] res_last_r;
  logic [crt_pkg::STAT_W-1:0] res_status_nxt;
  logic                       res_found_nxt;
  logic                       out_vld_r;
  logic                       in_acc;
  logic                       res_move;

  assign res_move = res_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = busy_r || (res_vld_r && !res_move);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r  <= '0;
      free0_r <= '0;
    end else begin
      tok0_r.active <= in_acc;
      if (in_acc) begin
        tok0_r.op         <= in_operation;
        tok0_r.first_addr <= in_first_addr;
        tok0_r.last_addr  <= in_last_addr;
        tok0_r.legal      <= in_legal_in;
        tok0_r.overlap    <= 1'b0;
        tok0_r.free_found <= 1'b0;
        tok0_r.done       <= 1'b0;
        tok0_r.hit_legal  <= 1'b0;
        tok0_r.hit_first  <= '0;
        tok0_r.hit_last   <= '0;
        free0_r           <= '0;
      end
    end
  end

  assign tok[0]      = tok0_r;
  assign free_idx[0] = free0_r;
  assign tail        = tok[ENTRIES];

  assign wr.en         = tail.active && (tail.op == crt_pkg::OP_ADD) &&
                         (tail.first_addr <= tail.last_addr) && !tail.overlap &&
                         tail.free_found;
  assign wr.first_addr = tail.first_addr;
  assign wr.last_addr  = tail.last_addr;
  assign wr.legal      = tail.legal;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    crt_cell #(
      .IDX        (g),
      .IDX_W      (IDX_W),
      .PAGE_SHIFT (PAGE_SHIFT)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok[g]),
      .free_in  (free_idx[g]),
      .wr       (wr),
      .wr_idx   (free_idx[ENTRIES]),
      .tok_out  (tok[g+1]),
      .free_out (free_idx[g+1])
    );
  end

  for (genvar g = 0; g <= ENTRIES; g++) begin : g_act
    assign act_vec[g] = tok[g].active;
  end

  always_comb begin
    res_found_nxt  = 1'b0;
    res_status_nxt = crt_pkg::ST_OK;
    case (tail.op)
      crt_pkg::OP_ADD: begin
        if (tail.first_addr > tail.last_addr) begin
          res_status_nxt = crt_pkg::ST_INVALID;
        end else if (tail.overlap) begin
          res_status_nxt = crt_pkg::ST_OVERLAP;
        end else if (!tail.free_found) begin
          res_status_nxt = crt_pkg::ST_FULL;
        end
      end
      crt_pkg::OP_DEL: begin
        if (!tail.done) begin
          res_status_nxt = crt_pkg::ST_NOT_FOUND;
        end
      end
      crt_pkg::OP_LKC, crt_pkg::OP_LKP: begin
        res_found_nxt = tail.done;
        if (!tail.done) begin
          res_status_nxt = crt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_status_nxt = crt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      res_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (tail.active) begin
        busy_r <= 1'b0;
      end
      if (tail.active) begin
        res_vld_r <= 1'b1;
      end else if (res_move) begin
        res_vld_r <= 1'b0;
      end
      if (res_move) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.active) begin
      res_status_r <= res_status_nxt;
      res_found_r  <= res_found_nxt;
      res_legal_r  <= res_found_nxt && tail.hit_legal;
      res_first_r  <= res_found_nxt ? tail.hit_first : '0;
      res_last_r   <= res_found_nxt ? tail.hit_last : '0;
    end
    if (res_move) begin
      out_status      <= res_status_r;
      out_found       <= res_found_r;
      out_found_legal <= res_legal_r;
      out_found_first <= res_first_r;
      out_found_last  <= res_last_r;
    end
  end

  assign out_valid = out_vld_r;

  `ASSERT_PROP(a_one_request, clk, rst_n, $onehot0(act_vec))
  `ASSERT_PROP(a_accept_busy, clk, rst_n, in_acc |=> busy_r)
  `ASSERT_PROP(a_tail_busy, clk, rst_n, tail.active |-> busy_r)
  `ASSERT_PROP(a_tail_result, clk, rst_n, tail.active |=> res_vld_r)
  `ASSERT_NEVER(a_busy_res, clk, rst_n, busy_r && res_vld_r)

endmodule
